@@ sv/irst_pkg.sv @@
// irst_pkg: shared constants, types and priority functions for the
// interrupt request / in-service tracker. No dependencies.
package irst_pkg;

  // Stored words per vector set (1 to 8), 32 vectors per word
  localparam int NUM_WORDS = 8;
  localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int VEC_W     = 8;
  localparam int VWORD_W   = VEC_W - BIT_W;

  // Item kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_EXIT    = 2'd1;
  localparam logic [1:0] KIND_EOI     = 2'd2;

  // Access request to one word store
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } store_req_t;

  // Highest set flag; 0 when none set
  function automatic logic [IDX_W-1:0] top_index(input logic [NUM_WORDS-1:0] flags);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (flags[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  // Highest set bit of a word; 0 when none set
  function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (word[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

@@ sv/irst_store.sv @@
// irst_store: one vector set held as a synchronous word memory with
// per-word nonzero flags. Depends on irst_pkg.
module irst_store (
  input  logic                               clk,
  input  logic                               rst,
  input  irst_pkg::store_req_t               req,
  output logic [irst_pkg::WORD_W-1:0]        rd_data,
  output logic [irst_pkg::NUM_WORDS-1:0]     nonzero
);

  logic [irst_pkg::WORD_W-1:0] mem [irst_pkg::NUM_WORDS];
  logic [irst_pkg::WORD_W-1:0] mem_q;
  logic [irst_pkg::IDX_W-1:0]  rd_addr_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q     <= mem[req.rd_addr];
      rd_addr_q <= req.rd_addr;
    end
  end

  // Flag clear means the word is zero, whatever the array holds
  always_ff @(posedge clk) begin
    if (rst) begin
      nonzero <= '0;
    end else if (req.wr_en) begin
      nonzero[req.wr_addr] <= |req.wr_data;
    end
  end

  assign rd_data = nonzero[rd_addr_q] ? mem_q : '0;

endmodule

@@ sv/interrupt_request_service_tracker.sv @@
// interrupt_request_service_tracker: top level, item sequencer over the
// pending and in-service word stores. Depends on irst_pkg, irst_store.
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+------------------------------------
//  in      | to block  | in_valid / in_stall  | kind, vector, window_open
//  out     | from block| out_valid / out_stall| deliver_valid, deliver_vector,
//          |           |                      | exit_request, highest_pending,
//          |           |                      | highest_in_service, pending_empty
//
// Each item goes from accept to result register through these steps:
// issue read, modify and write back, issue top-word read and register
// result. Per-word nonzero flags pick the top word without a scan.
// One item at a time; in_stall is high while an item is in flight.
// The result register holds while out_stall is high; the next item may be
// accepted and runs up to its last step meanwhile.
// Reset clears the nonzero flags and exit flag at once; no clearing pass.
module interrupt_request_service_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [irst_pkg::VEC_W-1:0]    vector,
  input  logic                          window_open,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          deliver_valid,
  output logic [irst_pkg::VEC_W-1:0]    deliver_vector,
  output logic                          exit_request,
  output logic [irst_pkg::VEC_W-1:0]    highest_pending,
  output logic [irst_pkg::VEC_W-1:0]    highest_in_service,
  output logic                          pending_empty
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_TOP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;

  // Latched item
  logic [1:0]                  kind_q;
  logic [irst_pkg::VEC_W-1:0]  vec_q;
  logic                        open_q;

  // Working registers
  logic [irst_pkg::IDX_W-1:0]  addr;
  logic                        found;
  logic                        dv;
  logic [irst_pkg::VEC_W-1:0]  dvec;
  logic                        exit_flag;
  logic [irst_pkg::IDX_W-1:0]  hp_addr;
  logic [irst_pkg::IDX_W-1:0]  hs_addr;
  logic                        hp_found;
  logic                        hs_found;

  irst_pkg::store_req_t         p_req;
  irst_pkg::store_req_t         s_req;
  logic [irst_pkg::WORD_W-1:0]  p_rd;
  logic [irst_pkg::WORD_W-1:0]  s_rd;
  logic [irst_pkg::NUM_WORDS-1:0] p_nz;
  logic [irst_pkg::NUM_WORDS-1:0] s_nz;

  logic [irst_pkg::IDX_W-1:0]  rd_addr;
  logic                        in_range;
  logic [irst_pkg::BIT_W-1:0]  bsel;
  logic [irst_pkg::WORD_W-1:0] mask;
  logic                        out_load;

  irst_store u_pending (
    .clk     (clk),
    .rst     (rst),
    .req     (p_req),
    .rd_data (p_rd),
    .nonzero (p_nz)
  );

  irst_store u_service (
    .clk     (clk),
    .rst     (rst),
    .req     (s_req),
    .rd_data (s_rd),
    .nonzero (s_nz)
  );

  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // Requests beyond the stored words are dropped
  assign in_range = ({1'b0, vec_q[irst_pkg::VEC_W-1:irst_pkg::BIT_W]} <
                     (irst_pkg::VWORD_W + 1)'(irst_pkg::NUM_WORDS));

  always_comb begin
    case (kind_q)
      irst_pkg::KIND_EXIT: rd_addr = irst_pkg::top_index(p_nz);
      irst_pkg::KIND_EOI:  rd_addr = irst_pkg::top_index(s_nz);
      default:             rd_addr = vec_q[irst_pkg::BIT_W +: irst_pkg::IDX_W];
    endcase
  end

  always_comb begin
    case (kind_q)
      irst_pkg::KIND_EXIT: bsel = irst_pkg::top_bit(p_rd);
      irst_pkg::KIND_EOI:  bsel = irst_pkg::top_bit(s_rd);
      default:             bsel = vec_q[irst_pkg::BIT_W-1:0];
    endcase
    mask = irst_pkg::WORD_W'(1) << bsel;
  end

  // Store accesses per step
  always_comb begin
    p_req = '0;
    s_req = '0;
    case (state)
      ST_RD: begin
        p_req.rd_en   = 1'b1;
        p_req.rd_addr = rd_addr;
        s_req.rd_en   = 1'b1;
        s_req.rd_addr = rd_addr;
      end
      ST_MOD: begin
        p_req.wr_addr = addr;
        s_req.wr_addr = addr;
        case (kind_q)
          irst_pkg::KIND_REQUEST: begin
            if (in_range) begin
              p_req.wr_en = 1'b1;
              if (open_q) begin
                p_req.wr_data = p_rd & ~mask;
                s_req.wr_en   = 1'b1;
                s_req.wr_data = s_rd | mask;
              end else begin
                p_req.wr_data = p_rd | mask;
              end
            end
          end
          irst_pkg::KIND_EXIT: begin
            if (found) begin
              p_req.wr_en   = 1'b1;
              p_req.wr_data = p_rd & ~mask;
              s_req.wr_en   = 1'b1;
              s_req.wr_data = s_rd | mask;
            end
          end
          irst_pkg::KIND_EOI: begin
            if (found) begin
              s_req.wr_en   = 1'b1;
              s_req.wr_data = s_rd & ~mask;
            end
          end
          default: begin
          end
        endcase
      end
      ST_TOP: begin
        p_req.rd_en   = 1'b1;
        p_req.rd_addr = irst_pkg::top_index(p_nz);
        s_req.rd_en   = 1'b1;
        s_req.rd_addr = irst_pkg::top_index(s_nz);
      end
      default: begin
      end
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      exit_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_RD;
        end
        ST_RD: begin
          state <= ST_MOD;
        end
        ST_MOD: begin
          if (kind_q == irst_pkg::KIND_REQUEST && in_range && !open_q) begin
            exit_flag <= 1'b1;
          end
          state <= ST_TOP;
        end
        ST_TOP: begin
          // Flags already reflect the write-back
          if (kind_q == irst_pkg::KIND_EXIT) exit_flag <= |p_nz;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      kind_q <= kind;
      vec_q  <= vector;
      open_q <= window_open;
      dv     <= 1'b0;
      dvec   <= '0;
    end
    if (state == ST_RD) begin
      addr  <= rd_addr;
      found <= (kind_q == irst_pkg::KIND_EOI) ? |s_nz : |p_nz;
    end
    if (state == ST_MOD) begin
      if (kind_q == irst_pkg::KIND_REQUEST && in_range && open_q) begin
        dv   <= 1'b1;
        dvec <= vec_q;
      end else if (kind_q == irst_pkg::KIND_EXIT && found) begin
        dv   <= 1'b1;
        dvec <= irst_pkg::VEC_W'({addr, bsel});
      end
    end
    if (state == ST_TOP) begin
      hp_addr  <= irst_pkg::top_index(p_nz);
      hs_addr  <= irst_pkg::top_index(s_nz);
      hp_found <= |p_nz;
      hs_found <= |s_nz;
    end
    if (out_load) begin
      deliver_valid      <= dv;
      deliver_vector     <= dvec;
      exit_request       <= exit_flag;
      highest_pending    <= hp_found ?
                            irst_pkg::VEC_W'({hp_addr, irst_pkg::top_bit(p_rd)}) : '0;
      highest_in_service <= hs_found ?
                            irst_pkg::VEC_W'({hs_addr, irst_pkg::top_bit(s_rd)}) : '0;
      pending_empty      <= !hp_found;
    end
  end

endmodule
